/* design/trb_pkg.sv */
// Shared types and constants for the triangle rasterizer.
package trb_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int DIM_W    = 11;  // screen size register width
    localparam int COORD_W  = 12;  // signed screen coordinate / difference
    localparam int EDGE_W   = 25;  // signed edge function value
    localparam int ATTR_W   = 17;  // signed attribute (depth or colour)
    localparam int ACC_W    = 44;  // weighted sum
    localparam int QUOT_W   = 17;  // quotient bits produced by the divider
    localparam int REM_W    = ACC_W - QUOT_W;
    localparam int CNT_W    = 5;
    localparam int NUM_LANES = 5;  // depth, B, G, R, A

    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(QUOT_W);
    localparam logic [CNT_W-1:0] MAC_LAST = CNT_W'(2);

    localparam logic       OP_LOAD      = 1'b0;
    localparam logic       OP_STEP      = 1'b1;
    localparam logic [1:0] SLOT_INVALID = 2'd3;
    localparam logic       CFG_WIDTH    = 1'b0;
    localparam logic       CFG_HEIGHT   = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MAP,
        S_STORE,
        S_SETUP_EDGE,
        S_SETUP_FIN,
        S_EDGE,
        S_MAC,
        S_DIV,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic       capture;
        logic       map_en;
        logic       store_en;
        logic       edge_en;
        logic       edge_v2;
        logic       setup_en;
        logic       mac_en;
        logic       mac_first;
        logic [1:0] mac_idx;
        logic       div_start;
        logic       div_step;
        logic       emit_en;
    } cmd_t;

    typedef struct packed {
        logic scan_active;
        logic out_busy;
    } status_t;

endpackage

/* design/trb_ctrl.sv */
// Sequencer for vertex loads, scan setup and per-pixel interpolation.
module trb_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             op,
    input  logic [1:0]       vertex_slot,
    output logic             in_ready,
    input  trb_pkg::status_t status,
    output trb_pkg::cmd_t    cmd
);
    import trb_pkg::*;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             accept;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                cnt_next = '0;
                if (accept)
                begin
                    if (op == OP_LOAD)
                    begin
                        if (vertex_slot != SLOT_INVALID)
                            state_next = S_MAP;
                    end
                    else if (status.scan_active)
                        state_next = S_EDGE;
                    else
                        state_next = S_EMIT;
                end
            end
            S_MAP:        state_next = S_STORE;
            S_STORE:      state_next = S_SETUP_EDGE;
            S_SETUP_EDGE: state_next = S_SETUP_FIN;
            S_SETUP_FIN:  state_next = S_IDLE;
            S_EDGE:       state_next = S_MAC;
            S_MAC:
            begin
                if (cnt_reg == MAC_LAST)
                begin
                    cnt_next   = '0;
                    state_next = S_DIV;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            S_DIV:
            begin
                if (cnt_reg == DIV_LAST)
                begin
                    cnt_next   = '0;
                    state_next = S_EMIT;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            S_EMIT:
            begin
                if (!status.out_busy)
                    state_next = S_IDLE;
            end
            default:      state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            S_IDLE:       cmd.capture = accept;
            S_MAP:        cmd.map_en = 1'b1;
            S_STORE:      cmd.store_en = 1'b1;
            S_SETUP_EDGE:
            begin
                cmd.edge_en = 1'b1;
                cmd.edge_v2 = 1'b1;
            end
            S_SETUP_FIN:  cmd.setup_en = 1'b1;
            S_EDGE:       cmd.edge_en = 1'b1;
            S_MAC:
            begin
                cmd.mac_en    = 1'b1;
                cmd.mac_first = (cnt_reg == '0);
                cmd.mac_idx   = cnt_reg[1:0];
            end
            S_DIV:
            begin
                cmd.div_start = (cnt_reg == '0);
                cmd.div_step  = (cnt_reg != '0);
            end
            S_EMIT:       cmd.emit_en = !status.out_busy;
            default:      cmd = '0;
        endcase
    end

endmodule

/* design/trb_datapath.sv */
// Vertex store, edge functions, weighted sums, dividers and result register.
module trb_datapath
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  trb_pkg::cmd_t               cmd,
    output trb_pkg::status_t            status,
    input  logic                        cfg_valid,
    input  logic                        cfg_index,
    input  logic [trb_pkg::DIM_W-1:0]   cfg_data,
    input  logic [1:0]                  vertex_slot,
    input  logic signed [15:0]          ndc_x,
    input  logic signed [15:0]          ndc_y,
    input  logic signed [15:0]          ndc_z,
    input  logic [7:0]                  col_b,
    input  logic [7:0]                  col_g,
    input  logic [7:0]                  col_r,
    input  logic [7:0]                  col_a,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        frag_valid,
    output logic [9:0]                  pix_x,
    output logic [9:0]                  pix_y,
    output logic signed [15:0]          frag_depth,
    output logic [7:0]                  out_b,
    output logic [7:0]                  out_g,
    output logic [7:0]                  out_r,
    output logic [7:0]                  out_a,
    output logic                        scan_done
);
    import trb_pkg::*;

    function automatic logic signed [EDGE_W-1:0] edge_fn(
        input logic signed [COORD_W-1:0] ax, input logic signed [COORD_W-1:0] ay,
        input logic signed [COORD_W-1:0] bx, input logic signed [COORD_W-1:0] by,
        input logic signed [COORD_W-1:0] px, input logic signed [COORD_W-1:0] py);
        logic signed [EDGE_W-1:0] p0;
        logic signed [EDGE_W-1:0] p1;
        p0 = EDGE_W'(px - ax) * EDGE_W'(by - ay);
        p1 = EDGE_W'(py - ay) * EDGE_W'(bx - ax);
        return p0 - p1;
    endfunction

    // configuration
    logic [DIM_W-1:0] width_reg, height_reg, w_eff, h_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_W'(640);
            height_reg <= DIM_W'(480);
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_WIDTH)
                width_reg <= cfg_data;
            else
                height_reg <= cfg_data;
        end
    end

    assign w_eff = (width_reg > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : width_reg;
    assign h_eff = (height_reg > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : height_reg;

    // captured load beat
    logic [1:0]         slot_reg;
    logic signed [15:0] x_in_reg, y_in_reg, z_in_reg;
    logic [7:0]         cb_reg, cg_reg, cr_reg, ca_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            slot_reg <= vertex_slot;
            x_in_reg <= ndc_x;
            y_in_reg <= ndc_y;
            z_in_reg <= ndc_z;
            cb_reg   <= col_b;
            cg_reg   <= col_g;
            cr_reg   <= col_r;
            ca_reg   <= col_a;
        end
    end

    // screen mapping
    logic [15:0] ux;
    logic [16:0] uy;
    logic [26:0] prod_x;
    logic [27:0] prod_y;
    logic [9:0]  sx_reg;
    logic [10:0] sy_reg;

    assign ux     = {~x_in_reg[15], x_in_reg[14:0]};
    assign uy     = 17'h08000 - {y_in_reg[15], y_in_reg};
    assign prod_x = 27'(ux) * 27'(w_eff);
    assign prod_y = 28'(uy) * 28'(h_eff);

    always_ff @(posedge clk)
    begin
        if (cmd.map_en)
        begin
            sx_reg <= prod_x[25:16];
            sy_reg <= prod_y[26:16];
        end
    end

    // vertex store
    logic [9:0]         vx_reg [3];
    logic [10:0]        vy_reg [3];
    logic signed [15:0] vz_reg [3];
    logic [7:0]         vc_reg [3][4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                vx_reg[i] <= '0;
                vy_reg[i] <= '0;
                vz_reg[i] <= '0;
                for (int c = 0; c < 4; c++)
                    vc_reg[i][c] <= '0;
            end
        end
        else if (cmd.store_en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (slot_reg == 2'(i))
                begin
                    vx_reg[i]    <= sx_reg;
                    vy_reg[i]    <= sy_reg;
                    vz_reg[i]    <= z_in_reg;
                    vc_reg[i][0] <= cb_reg;
                    vc_reg[i][1] <= cg_reg;
                    vc_reg[i][2] <= cr_reg;
                    vc_reg[i][3] <= ca_reg;
                end
            end
        end
    end

    logic signed [COORD_W-1:0] cx [3];
    logic signed [COORD_W-1:0] cy [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            cx[i] = $signed({2'b00, vx_reg[i]});
            cy[i] = $signed({1'b0, vy_reg[i]});
        end
    end

    // scan state
    logic [9:0]                cur_x_reg, cur_y_reg;
    logic [9:0]                min_x_reg;
    logic signed [COORD_W-1:0] max_x_reg, max_y_reg;
    logic signed [EDGE_W-1:0]  area_reg;
    logic                      active_reg;

    // edge functions
    logic signed [COORD_W-1:0] px, py;
    logic signed [EDGE_W-1:0]  e_reg [3];

    assign px = cmd.edge_v2 ? cx[2] : $signed({2'b00, cur_x_reg});
    assign py = cmd.edge_v2 ? cy[2] : $signed({2'b00, cur_y_reg});

    always_ff @(posedge clk)
    begin
        if (cmd.edge_en)
        begin
            e_reg[0] <= edge_fn(cx[1], cy[1], cx[2], cy[2], px, py);
            e_reg[1] <= edge_fn(cx[2], cy[2], cx[0], cy[0], px, py);
            e_reg[2] <= edge_fn(cx[0], cy[0], cx[1], cy[1], px, py);
        end
    end

    // bounding box
    logic [9:0]                bmin_x, bmax_x;
    logic [10:0]               bmin_y, bmax_y;
    logic signed [COORD_W-1:0] wlim, hlim, cmax_x, cmax_y;
    logic                      setup_live;

    always_comb
    begin
        bmin_x = vx_reg[0];
        bmax_x = vx_reg[0];
        bmin_y = vy_reg[0];
        bmax_y = vy_reg[0];
        for (int i = 1; i < 3; i++)
        begin
            if (vx_reg[i] < bmin_x) bmin_x = vx_reg[i];
            if (vx_reg[i] > bmax_x) bmax_x = vx_reg[i];
            if (vy_reg[i] < bmin_y) bmin_y = vy_reg[i];
            if (vy_reg[i] > bmax_y) bmax_y = vy_reg[i];
        end
    end

    assign wlim   = $signed({1'b0, w_eff}) - COORD_W'(1);
    assign hlim   = $signed({1'b0, h_eff}) - COORD_W'(1);
    assign cmax_x = ($signed({2'b00, bmax_x}) > wlim) ? wlim : $signed({2'b00, bmax_x});
    assign cmax_y = ($signed({1'b0, bmax_y}) > hlim) ? hlim : $signed({1'b0, bmax_y});
    assign setup_live = (e_reg[2] != '0)
                     && ($signed({2'b00, bmin_x}) <= cmax_x)
                     && ($signed({1'b0, bmin_y}) <= cmax_y);

    // emit bookkeeping
    logic in_tri, last_x, last_y;

    assign in_tri = ((!e_reg[0][EDGE_W-1]) && (!e_reg[1][EDGE_W-1]) && (!e_reg[2][EDGE_W-1]))
                 || ((e_reg[0] <= 0) && (e_reg[1] <= 0) && (e_reg[2] <= 0));
    assign last_x = $signed({2'b00, cur_x_reg}) >= max_x_reg;
    assign last_y = $signed({2'b00, cur_y_reg}) >= max_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg  <= '0;
            cur_y_reg  <= '0;
            min_x_reg  <= '0;
            max_x_reg  <= '0;
            max_y_reg  <= '0;
            area_reg   <= '0;
            active_reg <= 1'b0;
        end
        else if (cmd.setup_en)
        begin
            area_reg   <= e_reg[2];
            min_x_reg  <= bmin_x;
            max_x_reg  <= cmax_x;
            max_y_reg  <= cmax_y;
            cur_x_reg  <= bmin_x;
            cur_y_reg  <= bmin_y[9:0];
            active_reg <= setup_live;
        end
        else if (cmd.emit_en && active_reg)
        begin
            if (last_x && last_y)
                active_reg <= 1'b0;
            else if (last_x)
            begin
                cur_x_reg <= min_x_reg;
                cur_y_reg <= cur_y_reg + 1'b1;
            end
            else
                cur_x_reg <= cur_x_reg + 1'b1;
        end
    end

    // weighted sums, one vertex per cycle
    logic signed [ATTR_W-1:0]        attr [NUM_LANES];
    logic signed [ATTR_W+EDGE_W-1:0] prod [NUM_LANES];
    logic signed [EDGE_W-1:0]        wsel;
    logic signed [ACC_W-1:0]         acc_reg [NUM_LANES];
    logic [1:0]                      k;

    assign k    = (cmd.mac_idx == SLOT_INVALID) ? 2'd0 : cmd.mac_idx;
    assign wsel = e_reg[k];

    always_comb
    begin
        attr[0] = ATTR_W'(vz_reg[k]);
        for (int c = 0; c < 4; c++)
            attr[c+1] = $signed({1'b0, 8'(0), vc_reg[k][c]});
        for (int l = 0; l < NUM_LANES; l++)
            prod[l] = attr[l] * wsel;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mac_en)
        begin
            for (int l = 0; l < NUM_LANES; l++)
            begin
                if (cmd.mac_first)
                    acc_reg[l] <= ACC_W'(prod[l]);
                else
                    acc_reg[l] <= acc_reg[l] + ACC_W'(prod[l]);
            end
        end
    end

    // restoring dividers, one quotient bit per cycle in each lane
    logic [EDGE_W-1:0]  dvs;
    logic [ACC_W-1:0]   mag  [NUM_LANES];
    logic [REM_W-1:0]   rem_reg [NUM_LANES];
    logic [QUOT_W-1:0]  q_reg [NUM_LANES];
    logic               neg_reg [NUM_LANES];
    logic [REM_W:0]     trial [NUM_LANES];
    logic [QUOT_W-1:0]  quot [NUM_LANES];

    assign dvs = area_reg[EDGE_W-1] ? EDGE_W'(-area_reg) : EDGE_W'(area_reg);

    always_comb
    begin
        for (int l = 0; l < NUM_LANES; l++)
        begin
            mag[l]   = acc_reg[l][ACC_W-1] ? ACC_W'(-acc_reg[l]) : ACC_W'(acc_reg[l]);
            trial[l] = {rem_reg[l], q_reg[l][QUOT_W-1]};
            quot[l]  = neg_reg[l] ? QUOT_W'(-q_reg[l]) : q_reg[l];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int l = 0; l < NUM_LANES; l++)
        begin
            if (cmd.div_start)
            begin
                rem_reg[l] <= mag[l][ACC_W-1:QUOT_W];
                q_reg[l]   <= mag[l][QUOT_W-1:0];
                neg_reg[l] <= acc_reg[l][ACC_W-1] ^ area_reg[EDGE_W-1];
            end
            else if (cmd.div_step)
            begin
                if (trial[l] >= (REM_W+1)'(dvs))
                begin
                    rem_reg[l] <= REM_W'(trial[l] - (REM_W+1)'(dvs));
                    q_reg[l]   <= {q_reg[l][QUOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[l] <= trial[l][REM_W-1:0];
                    q_reg[l]   <= {q_reg[l][QUOT_W-2:0], 1'b0};
                end
            end
        end
    end

    // result register
    logic out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit_en)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_en)
        begin
            if (!active_reg)
            begin
                frag_valid <= 1'b0;
                pix_x      <= '0;
                pix_y      <= '0;
                frag_depth <= '0;
                out_b      <= '0;
                out_g      <= '0;
                out_r      <= '0;
                out_a      <= '0;
                scan_done  <= 1'b1;
            end
            else
            begin
                frag_valid <= in_tri;
                pix_x      <= cur_x_reg;
                pix_y      <= cur_y_reg;
                frag_depth <= in_tri ? $signed(quot[0][15:0]) : '0;
                out_b      <= in_tri ? quot[1][7:0] : '0;
                out_g      <= in_tri ? quot[2][7:0] : '0;
                out_r      <= in_tri ? quot[3][7:0] : '0;
                out_a      <= in_tri ? quot[4][7:0] : '0;
                scan_done  <= last_x && last_y;
            end
        end
    end

    assign out_valid          = out_valid_reg;
    assign status.scan_active = active_reg;
    assign status.out_busy    = out_valid_reg && !out_ready;

endmodule

/* design/triangle_rasterizer_bary.sv */
// Top level of the edge-function triangle rasterizer.
//
//   channel  | handshake               | beat
//   ---------+-------------------------+-------------------------------------------
//   input    | in_valid / in_ready     | op, vertex_slot, ndc_x/y/z, col_b/g/r/a
//   result   | out_valid / out_ready   | frag_valid, pix_x/y, frag_depth, out_*, scan_done
//   config   | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// A load runs through the map, store, edge setup and setup finish states. A step on
// an active scan runs edge evaluation, multiply-accumulate over the three vertices,
// divider load and the bit-serial divider steps, then the result write. An idle
// step goes straight to the result write. Reset gives a 640x480 screen, zeroed vertices
// and no scan. A full result register stalls the next write until the beat is taken.
module triangle_rasterizer_bary
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      op,
    input  logic [1:0]                vertex_slot,
    input  logic signed [15:0]        ndc_x,
    input  logic signed [15:0]        ndc_y,
    input  logic signed [15:0]        ndc_z,
    input  logic [7:0]                col_b,
    input  logic [7:0]                col_g,
    input  logic [7:0]                col_r,
    input  logic [7:0]                col_a,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic                      frag_valid,
    output logic [9:0]                pix_x,
    output logic [9:0]                pix_y,
    output logic signed [15:0]        frag_depth,
    output logic [7:0]                out_b,
    output logic [7:0]                out_g,
    output logic [7:0]                out_r,
    output logic [7:0]                out_a,
    output logic                      scan_done,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic                      cfg_index,
    input  logic [trb_pkg::DIM_W-1:0] cfg_data
);
    import trb_pkg::*;

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    trb_ctrl u_ctrl
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .op          (op),
        .vertex_slot (vertex_slot),
        .in_ready    (in_ready),
        .status      (status),
        .cmd         (cmd)
    );

    trb_datapath u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .vertex_slot (vertex_slot),
        .ndc_x       (ndc_x),
        .ndc_y       (ndc_y),
        .ndc_z       (ndc_z),
        .col_b       (col_b),
        .col_g       (col_g),
        .col_r       (col_r),
        .col_a       (col_a),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .frag_valid  (frag_valid),
        .pix_x       (pix_x),
        .pix_y       (pix_y),
        .frag_depth  (frag_depth),
        .out_b       (out_b),
        .out_g       (out_g),
        .out_r       (out_r),
        .out_a       (out_a),
        .scan_done   (scan_done)
    );

endmodule
